// ----- rtl/vfc_pkg.sv -----
// Shared types, codes and corner tables for the voxel face-cull mesher.
`default_nettype none
package vfc_pkg;

    localparam int CHUNK_EDGE_DEF = 16;

    // Request codes as carried on the input tuser.
    typedef enum logic [1:0] {
        REQ_WRITE    = 2'd0,
        REQ_MESH     = 2'd1,
        REQ_NEW_MESH = 2'd2,
        REQ_UNUSED   = 2'd3
    } req_t;

    // Commands queued between front and back.
    typedef enum logic [1:0] {
        CMD_WRITE    = 2'd0,
        CMD_MESH     = 2'd1,
        CMD_NEW_MESH = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [3:0] x;
        logic [3:0] y;
        logic [3:0] z;
        logic       active;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] tu;
        logic [7:0] tv;
    } cmd_t;

    typedef struct packed {
        logic       active;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] tu;
        logic [7:0] tv;
    } voxel_t;

    localparam logic [2:0] FACE_PZ   = 3'd0;
    localparam logic [2:0] FACE_NZ   = 3'd1;
    localparam logic [2:0] FACE_PX   = 3'd2;
    localparam logic [2:0] FACE_NX   = 3'd3;
    localparam logic [2:0] FACE_PY   = 3'd4;
    localparam logic [2:0] FACE_NY   = 3'd5;
    localparam logic [1:0] SLOT_LAST = 2'd3;

    // Cube corner offsets packed as {dx, dy, dz}.
    localparam logic [2:0] CUBE_CORNER [8] = '{
        3'b001, 3'b101, 3'b111, 3'b011, 3'b100, 3'b000, 3'b010, 3'b110
    };

    // Corner numbers per face in emission order.
    localparam logic [2:0] FACE_CORNERS [6][4] = '{
        '{3'd0, 3'd1, 3'd2, 3'd3},
        '{3'd4, 3'd5, 3'd6, 3'd7},
        '{3'd1, 3'd4, 3'd7, 3'd2},
        '{3'd5, 3'd0, 3'd3, 3'd6},
        '{3'd3, 3'd2, 3'd7, 3'd6},
        '{3'd5, 3'd4, 3'd1, 3'd0}
    };

    function automatic logic [2:0] corner_offset(input logic [2:0] face,
                                                 input logic [1:0] slot);
        return CUBE_CORNER[FACE_CORNERS[face][slot]];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/voxel_face_cull_mesher_core.sv -----
// Top level of the voxel hidden-face culling mesher.
// Order: an accepted beat is registered into the queue; a write or new-mesh command
// retires in the cycle it is popped. A mesh command first captures its center read, then
// runs 6 neighbor read/capture pairs, then emits up to 24 vertex beats at one per cycle
// while m_tready allows, passing over hidden faces; m_tvalid comes from a register.
// Throughput: one command in the back at a time; s_tready drops while the queue is full.
// After reset the store is zeroed one entry per cycle, all CHUNK_EDGE^3 entries
// (4096 by default), with s_tready low until the pass completes.
`default_nettype none
module voxel_face_cull_mesher_core #(
    parameter int CHUNK_EDGE = vfc_pkg::CHUNK_EDGE_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tuser: req_type[1:0]
    input  wire logic [1:0]  s_tuser,
    // s_tdata: voxel_x[3:0] voxel_y[7:4] voxel_z[11:8] active_in[12] color_r_in[20:13]
    //          color_g_in[28:21] color_b_in[36:29] tile_u_in[44:37] tile_v_in[52:45]
    input  wire logic [55:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tlast: last_vertex
    output logic             m_tlast,
    // m_tdata: corner_x[4:0] corner_y[9:5] corner_z[14:10] face_code[17:15]
    //          color_r[25:18] color_g[33:26] color_b[41:34] tex_u_half[50:42]
    //          tex_v_half[59:51] vertex_index[76:60]
    output logic [79:0]      m_tdata
);
    import vfc_pkg::*;

    logic clearing;
    logic q_full;
    logic push;
    cmd_t push_cmd;
    logic head_valid;
    cmd_t head;
    logic pop;

    // Classify and drop dead requests; a full queue or the clear pass stalls input.
    vfc_front #(.CHUNK_EDGE(CHUNK_EDGE)) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .clearing (clearing),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // Two-entry queue so the front can take commands while the back emits.
    vfc_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    // Store access, culling and vertex generation, strictly in queue order.
    vfc_back #(.CHUNK_EDGE(CHUNK_EDGE)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .clearing   (clearing),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tlast    (m_tlast),
        .m_tdata    (m_tdata)
    );

endmodule
`default_nettype wire

// ----- rtl/vfc_front.sv -----
// Front end: accepts request beats, drops dead ones, queues commands.
`default_nettype none
module vfc_front #(
    parameter int CHUNK_EDGE = vfc_pkg::CHUNK_EDGE_DEF
) (
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [1:0]    s_tuser,
    input  wire logic [55:0]   s_tdata,
    input  wire logic          clearing,
    input  wire logic          q_full,
    output logic               push,
    output vfc_pkg::cmd_t      push_cmd
);
    import vfc_pkg::*;

    logic in_chunk;
    logic keep;

    always_comb
    begin
        push_cmd.x      = s_tdata[3:0];
        push_cmd.y      = s_tdata[7:4];
        push_cmd.z      = s_tdata[11:8];
        push_cmd.active = s_tdata[12];
        push_cmd.r      = s_tdata[20:13];
        push_cmd.g      = s_tdata[28:21];
        push_cmd.b      = s_tdata[36:29];
        push_cmd.tu     = s_tdata[44:37];
        push_cmd.tv     = s_tdata[52:45];
        in_chunk = (int'(push_cmd.x) < CHUNK_EDGE) && (int'(push_cmd.y) < CHUNK_EDGE)
                && (int'(push_cmd.z) < CHUNK_EDGE);
        unique case (req_t'(s_tuser))
            REQ_WRITE:
            begin
                push_cmd.kind = CMD_WRITE;
                keep          = in_chunk;
            end
            REQ_MESH:
            begin
                push_cmd.kind = CMD_MESH;
                keep          = in_chunk;
            end
            REQ_NEW_MESH:
            begin
                push_cmd.kind = CMD_NEW_MESH;
                keep          = 1'b1;
            end
            default:
            begin
                push_cmd.kind = CMD_WRITE;
                keep          = 1'b0;
            end
        endcase
    end

    assign s_tready = !q_full && !clearing;
    assign push     = s_tvalid && s_tready && keep;

endmodule
`default_nettype wire

// ----- rtl/vfc_cmd_fifo.sv -----
// Two-entry command queue between front and back.
`default_nettype none
module vfc_cmd_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire vfc_pkg::cmd_t push_cmd,
    output logic               full,
    output logic               head_valid,
    output vfc_pkg::cmd_t      head,
    input  wire logic          pop
);
    import vfc_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full       = count_reg == 2'd2;
    assign head_valid = count_reg != 2'd0;
    assign head       = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule
`default_nettype wire

// ----- rtl/vfc_back.sv -----
// Back end: chunk store, neighbor test sequencer and vertex output register.
`default_nettype none
module vfc_back #(
    parameter int CHUNK_EDGE = vfc_pkg::CHUNK_EDGE_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          head_valid,
    input  wire vfc_pkg::cmd_t head,
    output logic               pop,
    output logic               clearing,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic               m_tlast,
    output logic [79:0]        m_tdata
);
    import vfc_pkg::*;

    localparam int EE    = CHUNK_EDGE * CHUNK_EDGE;
    localparam int DEPTH = EE * CHUNK_EDGE;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_CENTER, ST_NB_ISSUE, ST_NB_CAP, ST_EMIT
    } state_t;

    function automatic logic [AW-1:0] addr_of(input int x, input int y, input int z);
        int a;
        a = x * EE + y * CHUNK_EDGE + z;
        return a[AW-1:0];
    endfunction

    voxel_t        mem [DEPTH];
    voxel_t        rd_q;
    logic          we;
    logic [AW-1:0] wa;
    logic [AW-1:0] ra;
    voxel_t        wd;

    state_t        state_reg;
    logic [AW-1:0] clr_addr_reg;
    cmd_t          cur_reg;
    voxel_t        vox_reg;
    logic [5:0]    vis_reg;
    logic [2:0]    face_reg;
    logic [1:0]    slot_reg;
    logic [16:0]   idx_reg;
    logic          nb_inb_reg;
    logic          out_valid_reg;
    logic          out_last_reg;
    logic [79:0]   out_data_reg;

    int            nx, ny, nz;
    logic          nb_inb;
    logic [5:0]    vis_next;
    logic          out_free;
    logic          emit_go;
    logic          face_last;
    logic [2:0]    offs;
    logic [4:0]    cx, cy, cz;
    logic [8:0]    tu_h, tv_h;

    // Neighbor of the current voxel across face_reg.
    always_comb
    begin
        nx     = int'(cur_reg.x);
        ny     = int'(cur_reg.y);
        nz     = int'(cur_reg.z);
        nb_inb = 1'b1;
        case (face_reg)
            FACE_PZ:
            begin
                nz     = nz + 1;
                nb_inb = nz < CHUNK_EDGE;
            end
            FACE_NZ:
            begin
                nb_inb = nz != 0;
                nz     = nz - 1;
            end
            FACE_PX:
            begin
                nx     = nx + 1;
                nb_inb = nx < CHUNK_EDGE;
            end
            FACE_NX:
            begin
                nb_inb = nx != 0;
                nx     = nx - 1;
            end
            FACE_PY:
            begin
                ny     = ny + 1;
                nb_inb = ny < CHUNK_EDGE;
            end
            default:
            begin
                nb_inb = ny != 0;
                ny     = ny - 1;
            end
        endcase
    end

    always_comb
    begin
        we = 1'b0;
        wa = clr_addr_reg;
        wd = '0;
        ra = addr_of(int'(head.x), int'(head.y), int'(head.z));
        if (state_reg == ST_CLEAR)
        begin
            we = 1'b1;
        end
        else if (state_reg == ST_IDLE && head_valid && head.kind == CMD_WRITE)
        begin
            we = 1'b1;
            wa = ra;
            wd = '{active: head.active, r: head.r, g: head.g, b: head.b,
                   tu: head.tu, tv: head.tv};
        end
        if (state_reg == ST_NB_ISSUE)
        begin
            ra = addr_of(nx, ny, nz);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_q <= mem[ra];
    end

    always_comb
    begin
        vis_next           = vis_reg;
        vis_next[face_reg] = !(nb_inb_reg && rd_q.active);
        out_free           = !out_valid_reg || m_tready;
        emit_go            = state_reg == ST_EMIT && vis_reg[face_reg] && out_free;
        face_last          = (vis_reg & 6'(6'b111110 << face_reg)) == 6'd0;
        offs               = corner_offset(face_reg, slot_reg);
        cx                 = {1'b0, cur_reg.x} + {4'd0, offs[2]};
        cy                 = {1'b0, cur_reg.y} + {4'd0, offs[1]};
        cz                 = {1'b0, cur_reg.z} + {4'd0, offs[0]};
        tu_h               = {1'b0, vox_reg.tu} + {8'd0, slot_reg[0] ^ slot_reg[1]};
        tv_h               = {1'b0, vox_reg.tv} + {8'd0, slot_reg[1]};
    end

    assign pop      = state_reg == ST_IDLE && head_valid;
    assign clearing = state_reg == ST_CLEAR;
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            cur_reg       <= '0;
            vox_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            out_data_reg  <= '0;
            vis_reg       <= '0;
            face_reg      <= '0;
            slot_reg      <= '0;
            nb_inb_reg    <= 1'b0;
        end
        else
        begin
            // Hold the beat until taken; load a new one when the register frees up.
            out_valid_reg <= emit_go || (out_valid_reg && !m_tready);
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                    if (clr_addr_reg == AW'(DEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (head_valid)
                    begin
                        cur_reg <= head;
                        if (head.kind == CMD_NEW_MESH)
                        begin
                            idx_reg <= '0;
                        end
                        else if (head.kind == CMD_MESH)
                        begin
                            state_reg <= ST_CENTER;
                        end
                    end
                end
                ST_CENTER:
                begin
                    vox_reg  <= rd_q;
                    face_reg <= FACE_PZ;
                    vis_reg  <= '0;
                    state_reg <= rd_q.active ? ST_NB_ISSUE : ST_IDLE;
                end
                ST_NB_ISSUE:
                begin
                    nb_inb_reg <= nb_inb;
                    state_reg  <= ST_NB_CAP;
                end
                ST_NB_CAP:
                begin
                    vis_reg <= vis_next;
                    if (face_reg == FACE_NY)
                    begin
                        face_reg  <= FACE_PZ;
                        slot_reg  <= '0;
                        state_reg <= (vis_next == 6'd0) ? ST_IDLE : ST_EMIT;
                    end
                    else
                    begin
                        face_reg  <= face_reg + 3'd1;
                        state_reg <= ST_NB_ISSUE;
                    end
                end
                ST_EMIT:
                begin
                    if (!vis_reg[face_reg])
                    begin
                        face_reg <= face_reg + 3'd1;
                    end
                    else if (out_free)
                    begin
                        out_last_reg  <= slot_reg == SLOT_LAST && face_last;
                        out_data_reg  <= {3'd0, idx_reg, tv_h, tu_h, vox_reg.b, vox_reg.g,
                                          vox_reg.r, face_reg, cz, cy, cx};
                        idx_reg       <= idx_reg + 17'd1;
                        slot_reg      <= slot_reg + 2'd1;
                        if (slot_reg == SLOT_LAST)
                        begin
                            face_reg <= face_reg + 3'd1;
                            if (face_last)
                            begin
                                state_reg <= ST_IDLE;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !out_valid_reg)
        else $error("vertex beat during store clear");
    a_emit_has_face: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> vis_reg != 6'd0)
        else $error("emit with no visible face");
    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> state_reg == ST_IDLE && !clearing)
        else $error("command taken while busy");
    a_mesh_reads: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_NB_ISSUE |=> state_reg == ST_NB_CAP)
        else $error("neighbor read not captured");
`endif

endmodule
`default_nettype wire
